### src/moving_average_frame_rate_defines.svh
// Assertion macros for the moving-average frame-rate meter.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef MOVING_AVERAGE_FRAME_RATE_DEFINES_SVH
`define MOVING_AVERAGE_FRAME_RATE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MAFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MAFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mafr_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes of the moving-average frame-rate meter.
// No dependencies; imported by every module of the block.
package mafr_pkg;

    // Window and fixed-point format.
    localparam int MAX_WINDOW    = 256;
    localparam int FRACTION_BITS = 8;

    // Field widths.
    localparam int TS_W       = 64;
    localparam int IVL_W      = 32;
    localparam int RATE_W     = 24;
    localparam int STATUS_W   = 2;
    localparam int CNT_CFG_W  = 9;
    localparam int FREQ_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Derived datapath widths.
    localparam int RING_AW   = $clog2(MAX_WINDOW);
    localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W     = IVL_W + RING_AW;
    localparam int PROD_W    = WIN_W + FREQ_W;
    localparam int NUM_W     = PROD_W + FRACTION_BITS;
    localparam int NUM_HI_W  = NUM_W - RATE_W;
    localparam int DIV_STEPS = RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Queue between the front and back parts.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_FREQ   = 1'd1;
    localparam logic [CNT_CFG_W-1:0] SAMPLE_COUNT_RST = 9'd100;
    localparam logic [FREQ_W-1:0]    TIMER_FREQ_RST   = 32'd10000000;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_RATE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PRIMED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO   = 2'd2;

    // Classification of an accepted stamp.
    typedef enum logic [1:0] {
        KIND_RATE,
        KIND_PRIME,
        KIND_ZERO
    } kind_t;

    // One queued work item.
    typedef struct packed {
        kind_t            kind;
        logic [IVL_W-1:0] ivl;
    } item_t;

    // Queue fill status.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Configuration seen by the back part.
    typedef struct packed {
        logic [WIN_W-1:0]  win_len;
        logic [FREQ_W-1:0] timer_freq;
        logic              clear;
    } cfg_t;

    // Back part sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

### src/mafr_front.sv
`timescale 1ns / 1ps
// Front part: accepts timer stamps, forms the saturated interval and classifies the item.
// Depends on mafr_pkg.
module mafr_front
    import mafr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [TS_W-1:0]  timestamp,
    input  fifo_stat_t       fifo_stat,
    output logic             push,
    output item_t            push_item
);

    logic [TS_W-1:0]  prev_reg;
    logic [TS_W-1:0]  prev_next;
    logic             primed_reg;
    logic             primed_next;
    logic [TS_W-1:0]  diff;
    logic [IVL_W-1:0] ivl_sat;
    logic             accept;

    // A transfer happens whenever the queue has room.
    assign in_stall = fifo_stat.full;
    assign accept   = in_valid && !fifo_stat.full;
    assign push     = accept;

    // Interval modulo 2^64, saturated to 32 bits.
    assign diff    = timestamp - prev_reg;
    assign ivl_sat = (|diff[TS_W-1:IVL_W]) ? '1 : diff[IVL_W-1:0];

    // Classify: the first stamp only primes, a zero interval is ignored.
    always_comb
    begin
        push_item.ivl = ivl_sat;
        if (!primed_reg)
        begin
            push_item.kind = KIND_PRIME;
        end
        else if (ivl_sat == '0)
        begin
            push_item.kind = KIND_ZERO;
        end
        else
        begin
            push_item.kind = KIND_RATE;
        end
    end

    // Every accepted stamp becomes the previous stamp.
    always_comb
    begin
        prev_next   = prev_reg;
        primed_next = primed_reg;
        if (accept)
        begin
            prev_next   = timestamp;
            primed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            prev_reg   <= prev_next;
            primed_reg <= primed_next;
        end
    end

endmodule

### src/mafr_fifo.sv
`timescale 1ns / 1ps
// Short queue of classified items between the front and back parts.
// Depends on mafr_pkg.
module mafr_fifo
    import mafr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  item_t      push_item,
    input  logic       pop,
    output item_t      head,
    output fifo_stat_t stat
);

    item_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0] wr_ptr_reg;
    logic [FIFO_PW-1:0] wr_ptr_next;
    logic [FIFO_PW-1:0] rd_ptr_reg;
    logic [FIFO_PW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

    // Pointer and fill bookkeeping; pointers wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/mafr_back.sv
`timescale 1ns / 1ps
// Back part: interval ring, running sum, rate multiply, restoring divider and output register.
// Depends on mafr_pkg and moving_average_frame_rate_defines.svh.
`include "moving_average_frame_rate_defines.svh"
module mafr_back
    import mafr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  fifo_stat_t          fifo_stat,
    input  item_t               head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [RATE_W-1:0]   rate_fixed,
    output logic [STATUS_W-1:0] status
);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [RING_AW-1:0]   pos_reg;
    logic [RING_AW-1:0]   pos_next;
    logic [RING_AW-1:0]   wpos_reg;
    logic [RING_AW-1:0]   wpos_next;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [IVL_W-1:0]     ivl_reg;
    logic [IVL_W-1:0]     ivl_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    logic [SUM_W-1:0]     rem_reg;
    logic [SUM_W-1:0]     rem_next;
    logic [RATE_W-1:0]    quo_reg;
    logic [RATE_W-1:0]    quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [RATE_W-1:0]    res_rate_reg;
    logic [RATE_W-1:0]    res_rate_next;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [STATUS_W-1:0]  res_status_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [RATE_W-1:0]    out_rate_reg;
    logic [RATE_W-1:0]    out_rate_next;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [STATUS_W-1:0]  out_status_next;
    logic [MAX_WINDOW-1:0] vld_reg;
    logic [MAX_WINDOW-1:0] vld_next;

    // Ring memory with registered read data.
    logic [IVL_W-1:0]     ring_mem [MAX_WINDOW];
    logic [IVL_W-1:0]     rd_data_reg;
    logic                 rd_vld_reg;
    logic [RING_AW-1:0]   rd_addr;
    logic                 ring_we;

    logic [RING_AW-1:0]   pos_eff;
    logic [WIN_W-1:0]     pos_inc;
    logic [IVL_W-1:0]     old_ivl;
    logic [NUM_W-1:0]     num;
    logic [NUM_HI_W-1:0]  num_hi;
    logic                 ovf;
    logic [SUM_W:0]       trial;
    logic                 ge;
    logic                 load_out;
    logic                 div_last;

    // Slot to replace: the ring position, folded back if it lies past the window.
    assign pos_eff = (WIN_W'(pos_reg) >= cfg.win_len) ? '0 : pos_reg;
    assign rd_addr = pos_eff;

    // Evicted interval; slots never written since the last clear read as zero.
    assign old_ivl = rd_vld_reg ? rd_data_reg : '0;
    assign pos_inc = WIN_W'(wpos_reg) + WIN_W'(1);

    // Scaled numerator and saturation test: the quotient overflows 24 bits
    // exactly when the numerator's upper part already reaches the divisor.
    assign num    = NUM_W'(prod_reg) << FRACTION_BITS;
    assign num_hi = num[NUM_W-1:RATE_W];
    assign ovf    = NUM_W'(num_hi) >= NUM_W'(sum_reg);

    // One restoring divider step.
    assign trial = {rem_reg, quo_reg[RATE_W-1]};
    assign ge    = trial >= {1'b0, sum_reg};

    assign pop      = (state_reg == ST_IDLE) && !fifo_stat.empty;
    assign ring_we  = (state_reg == ST_READ);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign div_last = (state_reg == ST_DIV) && (cnt_reg == DIV_LAST);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    if (head.kind == KIND_RATE)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ovf ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates driven by the sequencer.
    always_comb
    begin
        pos_next        = pos_reg;
        wpos_next       = wpos_reg;
        sum_next        = sum_reg;
        ivl_next        = ivl_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        res_rate_next   = res_rate_reg;
        res_status_next = res_status_reg;
        vld_next        = vld_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    ivl_next      = head.ivl;
                    wpos_next     = pos_eff;
                    res_rate_next = '0;
                    case (head.kind)
                        KIND_PRIME: res_status_next = STATUS_PRIMED;
                        KIND_ZERO:  res_status_next = STATUS_ZERO;
                        KIND_RATE:  res_status_next = STATUS_RATE;
                        default:    res_status_next = STATUS_ZERO;
                    endcase
                end
            end
            ST_READ:
            begin
                // Swap the oldest interval for the new one.
                sum_next           = sum_reg - SUM_W'(old_ivl) + SUM_W'(ivl_reg);
                vld_next[wpos_reg] = 1'b1;
                pos_next           = (pos_inc >= cfg.win_len) ? '0 : pos_inc[RING_AW-1:0];
                prod_next          = PROD_W'(cfg.win_len) * PROD_W'(cfg.timer_freq);
            end
            ST_CHECK:
            begin
                if (ovf)
                begin
                    res_rate_next = '1;
                end
                else
                begin
                    rem_next = SUM_W'(num_hi);
                    quo_next = num[RATE_W-1:0];
                    cnt_next = '0;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? SUM_W'(trial - {1'b0, sum_reg}) : trial[SUM_W-1:0];
                quo_next = {quo_reg[RATE_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    res_rate_next = {quo_reg[RATE_W-2:0], ge};
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
        // A write of the window length empties the window.
        if (cfg.clear)
        begin
            pos_next = '0;
            sum_next = '0;
            vld_next = '0;
        end
    end

    // Output register: holds a finished result until its transfer.
    always_comb
    begin
        out_rate_next   = out_rate_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_rate_next   = res_rate_reg;
            out_status_next = res_status_reg;
            out_valid_next  = 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign rate_fixed = out_rate_reg;
    assign status     = out_status_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            sum_reg       <= '0;
            vld_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            vld_reg       <= vld_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        wpos_reg       <= wpos_next;
        ivl_reg        <= ivl_next;
        prod_reg       <= prod_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        res_rate_reg   <= res_rate_next;
        res_status_reg <= res_status_next;
        out_rate_reg   <= out_rate_next;
        out_status_reg <= out_status_next;
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wpos_reg] <= ivl_reg;
        end
        rd_data_reg <= ring_mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    // Sequencer and arithmetic checks.
    `MAFR_ASSERT_NOW(a_sum_nonzero, state_reg == ST_CHECK, sum_reg != '0, "zero window sum")
    `MAFR_ASSERT_NOW(a_rem_below_sum, state_reg == ST_DIV, rem_reg < sum_reg, "bad remainder")
    `MAFR_ASSERT_NOW(a_pos_in_window, 1'b1, WIN_W'(pos_reg) < cfg.win_len, "bad ring position")
    `MAFR_ASSERT_NEXT(a_div_ends, div_last, state_reg == ST_DONE, "divider overran")

endmodule

### src/moving_average_frame_rate.sv
`timescale 1ns / 1ps
// Top level of the moving-average frame-rate meter: configuration registers and the
// front part, queue and back part. Depends on mafr_pkg, mafr_front, mafr_fifo, mafr_back.
//
//   Channel   Direction  Handshake           Payload
//   input     in         in_valid/in_stall   timestamp[63:0]
//   result    out        out_valid/out_stall rate_fixed[23:0], status[1:0]
//   config    in         cfg_we              cfg_index[0], cfg_data[31:0]
//
// A stamp enters the two-entry queue in the cycle of its transfer.
// A priming stamp or a zero interval passes only through the idle and done states of the back part; a rate
// goes through ring read, sum update and multiply, saturation check, 24 divider steps and output load,
// skipping the divider when it saturates. The 24-step restoring divider sets the rate.
// Reset empties the window at once; a write of sample_count empties it again.
// A stalled result waits in the output register while the queue keeps taking stamps until it is full.
module moving_average_frame_rate
    import mafr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TS_W-1:0]       timestamp,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [RATE_W-1:0]     rate_fixed,
    output logic [STATUS_W-1:0]   status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CNT_CFG_W-1:0] sample_count_reg;
    logic [CNT_CFG_W-1:0] sample_count_next;
    logic [FREQ_W-1:0]    timer_freq_reg;
    logic [FREQ_W-1:0]    timer_freq_next;
    cfg_t                 cfg;
    fifo_stat_t           fifo_stat;
    logic                 push;
    item_t                push_item;
    logic                 pop;
    item_t                head;

    // Register write decode.
    always_comb
    begin
        sample_count_next = sample_count_reg;
        timer_freq_next   = timer_freq_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_COUNT: sample_count_next = cfg_data[CNT_CFG_W-1:0];
                REG_TIMER_FREQ:   timer_freq_next   = cfg_data[FREQ_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RST;
            timer_freq_reg   <= TIMER_FREQ_RST;
        end
        else
        begin
            sample_count_reg <= sample_count_next;
            timer_freq_reg   <= timer_freq_next;
        end
    end

    // Window length clamped to one through the ring depth.
    always_comb
    begin
        if (sample_count_reg == '0)
        begin
            cfg.win_len = WIN_W'(1);
        end
        else if (32'(sample_count_reg) > 32'(MAX_WINDOW))
        begin
            cfg.win_len = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            cfg.win_len = WIN_W'(sample_count_reg);
        end
        cfg.timer_freq = timer_freq_reg;
        cfg.clear      = cfg_we && (cfg_index == REG_SAMPLE_COUNT);
    end

    mafr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .timestamp (timestamp),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_item (push_item)
    );

    mafr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (fifo_stat)
    );

    mafr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .fifo_stat  (fifo_stat),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rate_fixed (rate_fixed),
        .status     (status)
    );

endmodule

### tb/tb_moving_average_frame_rate.sv
`timescale 1ns / 1ps
// Self-checking testbench for the moving-average frame-rate meter.
// Depends on mafr_pkg and moving_average_frame_rate; stamps go in, rates are predicted and checked.
module tb_moving_average_frame_rate;
    import mafr_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [RATE_W-1:0]   rate;
        logic [STATUS_W-1:0] status;
    } frame_result_t;

    // Block ports.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [TS_W-1:0]       timestamp = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [RATE_W-1:0]     rate_fixed;
    logic [STATUS_W-1:0]   status;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Stamps waiting to be sent and results waiting to arrive.
    logic [TS_W-1:0] stamp_pending[$];
    frame_result_t   rate_expected[$];

    int          fail_count  = 0;
    int unsigned cycle_count = 0;

    // Predictor state: the window of intervals and its configuration.
    logic [IVL_W-1:0]     win_ring [MAX_WINDOW];
    int unsigned          win_pos;
    logic [63:0]          win_sum;
    logic [TS_W-1:0]      last_stamp;
    bit                   stamp_seen;
    logic [CNT_CFG_W-1:0] cfg_count;
    logic [FREQ_W-1:0]    cfg_freq;

    // Pacing state of the sender and the receiver.
    int in_gap       = 0;
    int in_run_left  = 0;
    bit in_calm      = 1'b0;
    int out_hold     = 0;
    int out_run_left = 0;
    bit out_calm     = 1'b0;

    moving_average_frame_rate u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .timestamp  (timestamp),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rate_fixed (rate_fixed),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic void clear_window();
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            win_ring[i] = '0;
        end
        win_pos = 0;
        win_sum = '0;
    endfunction

    // Works out the result of one accepted stamp and queues it.
    function automatic void predict_frame(input logic [TS_W-1:0] stamp);
        frame_result_t res;
        logic [63:0]   diff;
        logic [IVL_W-1:0] ivl;
        int unsigned   n;
        int unsigned   slot;
        logic [63:0]   num;
        logic [63:0]   quot;
        res.rate = '0;
        if (!stamp_seen)
        begin
            last_stamp = stamp;
            stamp_seen = 1'b1;
            res.status = STATUS_PRIMED;
        end
        else
        begin
            diff = stamp - last_stamp;
            last_stamp = stamp;
            ivl = (diff > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[IVL_W-1:0];
            if (ivl == '0)
            begin
                res.status = STATUS_ZERO;
            end
            else
            begin
                // Window length: zero acts as one, oversize acts as the maximum.
                n = cfg_count;
                if (n == 0)
                    n = 1;
                if (n > MAX_WINDOW)
                    n = MAX_WINDOW;
                slot = win_pos;
                if (slot >= n)
                    slot = 0;
                win_sum = win_sum - 64'(win_ring[slot]) + 64'(ivl);
                win_ring[slot] = ivl;
                slot++;
                if (slot >= n)
                    slot = 0;
                win_pos = slot;
                num = (64'(n) * 64'(cfg_freq)) << FRACTION_BITS;
                quot = num / win_sum;
                res.rate = (quot > 64'hFF_FFFF) ? 24'hFF_FFFF : quot[RATE_W-1:0];
                res.status = STATUS_RATE;
            end
        end
        rate_expected.push_back(res);
    endfunction

    // Cycles to wait before the next item, in runs of calm or busy pacing drawn at random.
    function automatic int draw_wait(inout int run_left, inout bit calm);
        if (run_left == 0)
        begin
            run_left = $urandom_range(20, 60);
            calm = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    // Driver: presents pending stamps and holds each one until its transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            timestamp <= '0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_frame(timestamp);
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (stamp_pending.size() != 0)
                begin
                    timestamp <= stamp_pending[0];
                    stamp_pending.delete(0);
                    in_valid  <= 1'b1;
                    in_gap = draw_wait(in_run_left, in_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and stalls at random after it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_hold = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (rate_expected.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result rate=%0d status=%0d",
                                              rate_fixed, status));
                end
                else
                begin
                    if (rate_fixed !== rate_expected[0].rate)
                        report_mismatch($sformatf("rate_fixed %0d, predicted %0d",
                                                  rate_fixed, rate_expected[0].rate));
                    if (status !== rate_expected[0].status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  status, rate_expected[0].status));
                    rate_expected.delete(0);
                end
                out_hold = draw_wait(out_run_left, out_calm);
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Register write; the write enable stays high until end_writes.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_SAMPLE_COUNT)
        begin
            cfg_count = data[CNT_CFG_W-1:0];
            clear_window();
        end
        else
        begin
            cfg_freq = data[FREQ_W-1:0];
        end
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    // Waits until every stamp is sent and every result has arrived, then lets the block settle.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (stamp_pending.size() != 0 || in_valid || rate_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_stamps(input logic [TS_W-1:0] stamps[$]);
        @(negedge clk);
        foreach (stamps[i])
            stamp_pending.push_back(stamps[i]);
        wait_idle();
    endtask

    function automatic logic [63:0] pick_interval();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 64'($urandom_range(1000, 400000));
        if (pick < 55)
            return 64'($urandom_range(1, 255));
        if (pick < 63)
            return 64'd0;
        if (pick < 70)
            return {32'd0, $urandom()};
        if (pick < 76)
            return 64'h1_0000_0000 + 64'($urandom_range(0, 2)) - 64'd1;
        if (pick < 81)
            return {24'd0, 8'($urandom()), $urandom()};
        return 64'($urandom_range(400000, 20000000));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_count();
        logic [CNT_CFG_W-1:0] cnt;
        case ($urandom_range(0, 10))
            0: cnt = 9'd1;
            1: cnt = 9'd2;
            2: cnt = 9'd3;
            3: cnt = 9'd100;
            4: cnt = 9'd255;
            5: cnt = 9'd256;
            6: cnt = 9'd257;
            7: cnt = 9'd511;
            8: cnt = 9'd0;
            9: cnt = 9'($urandom_range(1, 20));
            default: cnt = 9'($urandom_range(0, 511));
        endcase
        return {23'($urandom()), cnt};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_freq();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'd1000;
            4, 5: return 32'd10000000;
            6: return $urandom();
            default: return 32'($urandom_range(1000000, 100000000));
        endcase
    endfunction

    // Stimulus and end of run.
    initial
    begin
        logic [TS_W-1:0] stamps[$];
        logic [TS_W-1:0] stamp;
        int              sent;
        int              count;

        cfg_count  = SAMPLE_COUNT_RST;
        cfg_freq   = TIMER_FREQ_RST;
        clear_window();
        last_stamp = '0;
        stamp_seen = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: priming, wrap past the top, zero interval, saturated intervals.
        stamps = '{64'hFFFF_FFFF_FFFF_FFF0, 64'h10, 64'h10, 64'h11,
                   64'h11 + 64'd166667,
                   64'h11 + 64'd166667 + 64'hFFFF_FFFF,
                   64'h11 + 64'd166667 + 64'hFFFF_FFFF + 64'h1_0000_0000,
                   64'h8000_0000_0000_0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
        send_stamps(stamps);

        // One-slot window at the highest frequency: the rate saturates.
        write_register(REG_SAMPLE_COUNT, 32'd1);
        write_register(REG_TIMER_FREQ, 32'hFFFF_FFFF);
        end_writes();
        stamps = '{64'h1, 64'h1_0000_0000, 64'h1_0000_0000, 64'h1_0000_03E8};
        send_stamps(stamps);

        // Window length zero acts as one; zero frequency gives rate zero.
        write_register(REG_SAMPLE_COUNT, 32'hFFFF_FE00);
        write_register(REG_TIMER_FREQ, 32'd0);
        end_writes();
        stamps = '{64'h1_0000_03ED, 64'h1_0000_03F4};
        send_stamps(stamps);

        // Oversize window length acts as the maximum.
        write_register(REG_SAMPLE_COUNT, 32'h0000_01FF);
        write_register(REG_TIMER_FREQ, 32'd10000000);
        end_writes();
        stamps = '{64'h1_000F_4628, 64'h1_001E_8868, 64'h1_002D_CAA8};
        send_stamps(stamps);

        write_register(REG_SAMPLE_COUNT, 32'd256);
        write_register(REG_TIMER_FREQ, 32'd1);
        end_writes();
        stamps = '{64'h1_002D_CAB0, 64'h1_002D_CAC0};
        send_stamps(stamps);

        // Random phases; each ends with the sender paused until all results are in.
        stamp = 64'h1_002D_CAC0;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
                write_register(REG_SAMPLE_COUNT, pick_count());
            if ($urandom_range(0, 9) < 7)
                write_register(REG_TIMER_FREQ, pick_freq());
            end_writes();
            if ($urandom_range(0, 4) == 0)
                stamp = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3000000));
            count = $urandom_range(60, 300);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            stamps = {};
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(0, 99) < 5)
                    stamp = {$urandom(), $urandom()};
                else
                    stamp = stamp + pick_interval();
                stamps.push_back(stamp);
            end
            send_stamps(stamps);
            sent += count;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (rate_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", rate_expected.size()));
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog on the total run length.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_count);
        $display("FAILURE");
        $finish;
    end

endmodule
